// ----- rtl/swfe_pkg.sv -----
// Package for the sync word frame extractor: frame geometry, reset values
// and the struct of angle words passed from the angle byte store.
// Depends on nothing.
package swfe_pkg;

  // Bytes in one frame after the sync word; legal range is 23 to 63.
  localparam int unsigned FRAME_BYTES = 40;
  // Width of the frame position counter; it must hold FRAME_BYTES itself.
  localparam int unsigned POS_W = 6;
  // Position of the first angle byte (low byte of yaw) in the frame.
  localparam int unsigned YAW_FIRST = 11;
  // Number of angle bytes: yaw, pitch and roll, four bytes each.
  localparam int unsigned ANGLE_COUNT = 12;
  // Sync word after reset.
  localparam logic [31:0] SYNC_RESET = 32'h3031_20ff;

  // Position that means the block is hunting for the sync word.
  localparam logic [POS_W-1:0] POS_HUNT = POS_W'(FRAME_BYTES);
  // Position of the last byte of a frame.
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_ANGLE_LO = POS_W'(YAW_FIRST);
  localparam logic [POS_W-1:0] POS_ANGLE_HI = POS_W'(YAW_FIRST + ANGLE_COUNT - 1);

  typedef struct packed {
    logic [31:0] yaw_bits;
    logic [31:0] pitch_bits;
    logic [31:0] roll_bits;
  } angles_t;

endpackage

// ----- rtl/swfe_if.sv -----
// Valid/ready channel interfaces for the sync word frame extractor:
// a byte channel for the serial input and an angle channel for results.
// Depends on nothing.
interface swfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface swfe_angle_if;
  logic        valid;
  logic        ready;
  logic [31:0] yaw_bits;
  logic [31:0] pitch_bits;
  logic [31:0] roll_bits;

  modport source (output valid, output yaw_bits, output pitch_bits, output roll_bits,
                  input ready);
  modport sink (input valid, input yaw_bits, input pitch_bits, input roll_bits,
                output ready);
endinterface

// ----- rtl/swfe_angle_store.sv -----
// Angle byte store: a twelve byte shift line that captures frame bytes 11
// to 22 in arrival order. Depends on swfe_pkg.
module swfe_angle_store (
  input  logic            clk,
  input  logic            shift_en,
  input  logic [7:0]      data_byte,
  output swfe_pkg::angles_t angles
);

  logic [7:0] angle_bytes [swfe_pkg::ANGLE_COUNT];
  logic [7:0] angle_bytes_next [swfe_pkg::ANGLE_COUNT];

  // Bytes enter at the top and move down, so after a whole frame entry 0
  // holds frame byte 11. The words are taken from the next contents so a
  // frame that ends on an angle byte still sees it.
  always_comb begin
    for (int i = 0; i < swfe_pkg::ANGLE_COUNT; i++) begin
      angle_bytes_next[i] = angle_bytes[i];
    end
    if (shift_en) begin
      for (int i = 0; i < swfe_pkg::ANGLE_COUNT - 1; i++) begin
        angle_bytes_next[i] = angle_bytes[i+1];
      end
      angle_bytes_next[swfe_pkg::ANGLE_COUNT-1] = data_byte;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < swfe_pkg::ANGLE_COUNT; i++) begin
      angle_bytes[i] <= angle_bytes_next[i];
    end
  end

  assign angles.yaw_bits   = {angle_bytes_next[3], angle_bytes_next[2],
                              angle_bytes_next[1], angle_bytes_next[0]};
  assign angles.pitch_bits = {angle_bytes_next[7], angle_bytes_next[6],
                              angle_bytes_next[5], angle_bytes_next[4]};
  assign angles.roll_bits  = {angle_bytes_next[11], angle_bytes_next[10],
                              angle_bytes_next[9], angle_bytes_next[8]};

endmodule

// ----- rtl/sync_word_frame_extractor_core.sv -----
// Top level of the sync word frame extractor: sync hunt, frame counter and
// the result register. Depends on swfe_pkg, swfe_if.sv and swfe_angle_store.
//
//   channel     direction  beat carries                      handshake
//   byte_in     in         data_byte, one serial byte         valid/ready
//   angle_out   out        yaw_bits, pitch_bits, roll_bits    valid/ready
//   sync_word   in         sync_word_wdata                    sync_word_we
//
// Every byte beat is handled in the cycle it is accepted, so one byte is
// taken per clock but for the stall described below; a frame result
// appears in angle_out in the cycle after the last frame byte is accepted.
// Reset (rst, synchronous) puts the block in the hunting state with a
// cleared sync window and the default sync word, and drops angle_out.valid.
// A stall on angle_out holds back byte_in only when the byte about to be
// accepted would finish another frame; every other byte keeps flowing.
module sync_word_frame_extractor_core (
  input  logic                 clk,
  input  logic                 rst,
  swfe_byte_if.sink            byte_in,
  swfe_angle_if.source         angle_out,
  input  logic                 sync_word_we,
  input  logic [31:0]          sync_word_wdata
);

  logic [31:0]              sync_word;
  logic [31:0]              sync_window;
  logic [31:0]              sync_window_next;
  logic [swfe_pkg::POS_W-1:0] frame_pos;
  logic [swfe_pkg::POS_W-1:0] frame_pos_next;
  logic                     out_valid;
  swfe_pkg::angles_t        out_angles;
  swfe_pkg::angles_t        store_angles;
  logic                     in_accept;
  logic                     hunting;
  logic                     emit;
  logic                     angle_shift;
  logic [31:0]              shifted_window;

  // The byte that completes a frame may only enter when the result register
  // is free or is being emptied in this cycle.
  assign byte_in.ready = !out_valid || angle_out.ready || (frame_pos != swfe_pkg::POS_LAST);
  assign in_accept     = byte_in.valid && byte_in.ready;
  assign hunting       = (frame_pos >= swfe_pkg::POS_HUNT);
  assign emit          = in_accept && (frame_pos == swfe_pkg::POS_LAST);
  assign angle_shift   = in_accept && (frame_pos >= swfe_pkg::POS_ANGLE_LO)
                         && (frame_pos <= swfe_pkg::POS_ANGLE_HI);
  assign shifted_window = {sync_window[23:0], byte_in.data_byte};

  // While hunting the byte shifts into the window and is compared after the
  // shift; a match clears the window so the next sync must come in fresh
  // bytes. While collecting, the window stays clear and only the counter
  // moves.
  always_comb begin
    sync_window_next = sync_window;
    frame_pos_next   = frame_pos;
    if (in_accept) begin
      if (hunting) begin
        if (shifted_window == sync_word) begin
          sync_window_next = '0;
          frame_pos_next   = '0;
        end else begin
          sync_window_next = shifted_window;
        end
      end else begin
        frame_pos_next = frame_pos + 1'b1;
      end
    end
  end

  swfe_angle_store u_angle_store (
    .clk       (clk),
    .shift_en  (angle_shift),
    .data_byte (byte_in.data_byte),
    .angles    (store_angles)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word   <= swfe_pkg::SYNC_RESET;
      sync_window <= '0;
      frame_pos   <= swfe_pkg::POS_HUNT;
      out_valid   <= 1'b0;
    end else begin
      if (sync_word_we) begin
        sync_word <= sync_word_wdata;
      end
      sync_window <= sync_window_next;
      frame_pos   <= frame_pos_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (angle_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_angles <= store_angles;
    end
  end

  assign angle_out.valid      = out_valid;
  assign angle_out.yaw_bits   = out_angles.yaw_bits;
  assign angle_out.pitch_bits = out_angles.pitch_bits;
  assign angle_out.roll_bits  = out_angles.roll_bits;

  // The counter never runs past the hunting value.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    frame_pos <= swfe_pkg::POS_HUNT)
    else $error("frame position out of range");

  // The sync window stays clear for the whole of a frame.
  a_window_clear: assert property (@(posedge clk) disable iff (rst)
    (frame_pos < swfe_pkg::POS_HUNT) |-> (sync_window == '0))
    else $error("sync window not clear while collecting");

  // Finishing a frame returns to hunting with a result waiting.
  a_emit: assert property (@(posedge clk) disable iff (rst)
    emit |=> (out_valid && frame_pos == swfe_pkg::POS_HUNT))
    else $error("frame end did not produce a result");

  // Input is held back only for a frame end behind a stalled result.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !byte_in.ready |-> (out_valid && !angle_out.ready && frame_pos == swfe_pkg::POS_LAST))
    else $error("byte input stalled without cause");

endmodule

// ----- verif/swfe_frame_checker.sv -----
// Scoreboard for the sync word frame extractor: follows the byte, angle and
// sync word traffic, predicts each frame's angle words and compares them.
// Depends on swfe_pkg.
module swfe_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic        byte_ready,
  input  logic [7:0]  data_byte,
  input  logic        angle_valid,
  input  logic        angle_ready,
  input  logic [31:0] yaw_bits,
  input  logic [31:0] pitch_bits,
  input  logic [31:0] roll_bits,
  input  logic        sync_word_we,
  input  logic [31:0] sync_word_wdata,
  output int unsigned mismatches,
  output int unsigned frames_pending,
  output int unsigned bytes_seen,
  output int unsigned frames_seen
);

  // Shadow copy of the deframer state.
  logic [31:0]                sync_word;
  logic [31:0]                sync_window;
  logic [swfe_pkg::POS_W-1:0] frame_pos;
  logic [7:0]                 angle_bytes [swfe_pkg::ANGLE_COUNT];
  swfe_pkg::angles_t          pending_angles [$];

  int unsigned error_count = 0;
  int unsigned byte_count = 0;
  int unsigned result_count = 0;

  always @(posedge clk) begin : track
    swfe_pkg::angles_t want;
    if (rst) begin
      sync_word = swfe_pkg::SYNC_RESET;
      sync_window = '0;
      frame_pos = swfe_pkg::POS_HUNT;
      pending_angles.delete();
    end else begin
      // The result of a frame is registered in the core, so it never shows up
      // in the cycle of its last byte, and the compare goes first.
      if (angle_valid && angle_ready) begin
        result_count++;
        if (pending_angles.size() == 0) begin
          error_count++;
          $error("angle beat with no frame pending: yaw_bits %h pitch_bits %h roll_bits %h",
                 yaw_bits, pitch_bits, roll_bits);
        end else begin
          want = pending_angles.pop_front();
          if (yaw_bits !== want.yaw_bits) begin
            error_count++;
            $error("yaw_bits: expected %h, actual %h", want.yaw_bits, yaw_bits);
          end
          if (pitch_bits !== want.pitch_bits) begin
            error_count++;
            $error("pitch_bits: expected %h, actual %h", want.pitch_bits, pitch_bits);
          end
          if (roll_bits !== want.roll_bits) begin
            error_count++;
            $error("roll_bits: expected %h, actual %h", want.roll_bits, roll_bits);
          end
        end
      end

      if (byte_valid && byte_ready) begin
        byte_count++;
        if (frame_pos >= swfe_pkg::POS_HUNT) begin
          sync_window = {sync_window[23:0], data_byte};
          if (sync_window == sync_word) begin
            frame_pos = '0;
            sync_window = '0;
          end
        end else begin
          if (frame_pos >= swfe_pkg::POS_ANGLE_LO && frame_pos <= swfe_pkg::POS_ANGLE_HI)
            angle_bytes[4'(frame_pos - swfe_pkg::POS_ANGLE_LO)] = data_byte;
          frame_pos = frame_pos + 1'b1;
          if (frame_pos == swfe_pkg::POS_HUNT) begin
            want.yaw_bits   = {angle_bytes[3], angle_bytes[2], angle_bytes[1], angle_bytes[0]};
            want.pitch_bits = {angle_bytes[7], angle_bytes[6], angle_bytes[5], angle_bytes[4]};
            want.roll_bits  = {angle_bytes[11], angle_bytes[10], angle_bytes[9], angle_bytes[8]};
            pending_angles.push_back(want);
          end
        end
      end

      // A new sync word applies from the next byte on.
      if (sync_word_we)
        sync_word = sync_word_wdata;
    end

    mismatches     <= error_count;
    frames_pending <= pending_angles.size();
    bytes_seen     <= byte_count;
    frames_seen    <= result_count;
  end

endmodule

// ----- verif/testbench.sv -----
// Top of the sync word frame extractor testbench: clock, reset, byte and
// result stimulus, sync word changes, watchdog and verdict.
// Depends on swfe_pkg, swfe_if.sv, swfe_frame_checker and the core.
module testbench;

  // Cycles without any beat before the run is declared hung. The longest
  // legal quiet stretch is the long result hold-off below.
  localparam int unsigned QUIET_LIMIT   = 4000;
  // Margin after the last result has left the core, before a sync word
  // change or the verdict.
  localparam int unsigned SETTLE_CYCLES = 4;
  // Length of the one long stall on the result side.
  localparam int unsigned HOLD_CYCLES   = 400;
  // Rough number of byte beats in each random phase.
  localparam int unsigned PHASE_BYTES   = 300;
  localparam int unsigned PHASE_COUNT   = 5;

  logic        clk = 1'b0;
  logic        rst;
  logic        sync_word_we;
  logic [31:0] sync_word_wdata;

  // Sync word currently programmed, used to build sync sequences.
  logic [31:0] sync_setting;
  int unsigned settings_used = 0;
  int unsigned sent_bytes = 0;
  // When set, neither side inserts gaps.
  bit          no_idle = 1'b0;
  bit          hold_done = 1'b0;
  logic [7:0]  frame_buf [swfe_pkg::FRAME_BYTES];

  int unsigned mismatches;
  int unsigned frames_pending;
  int unsigned bytes_seen;
  int unsigned frames_seen;
  int unsigned quiet_cycles = 0;

  swfe_byte_if  byte_ch ();
  swfe_angle_if angle_ch ();

  sync_word_frame_extractor_core dut (
    .clk             (clk),
    .rst             (rst),
    .byte_in         (byte_ch),
    .angle_out       (angle_ch),
    .sync_word_we    (sync_word_we),
    .sync_word_wdata (sync_word_wdata)
  );

  swfe_frame_checker frame_check (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (byte_ch.valid),
    .byte_ready      (byte_ch.ready),
    .data_byte       (byte_ch.data_byte),
    .angle_valid     (angle_ch.valid),
    .angle_ready     (angle_ch.ready),
    .yaw_bits        (angle_ch.yaw_bits),
    .pitch_bits      (angle_ch.pitch_bits),
    .roll_bits       (angle_ch.roll_bits),
    .sync_word_we    (sync_word_we),
    .sync_word_wdata (sync_word_wdata),
    .mismatches      (mismatches),
    .frames_pending  (frames_pending),
    .bytes_seen      (bytes_seen),
    .frames_seen     (frames_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length in cycles: mostly none, often short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Byte content with extra weight on all zeros and all ones.
  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0)
      return 8'h00;
    if (r == 1)
      return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  // Offers one byte beat and waits until the core takes it. The valid stays
  // high into the next beat unless a gap follows, so it is never lowered
  // and raised within the same step.
  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= value;
    do begin
      @(posedge clk);
    end while (!byte_ch.ready);
    sent_bytes++;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The window shifts left with the new byte at the bottom, so the sync
  // word goes out most significant byte first.
  task automatic send_sync();
    for (int k = 0; k < 4; k++)
      send_byte(sync_setting[31 - 8 * k -: 8]);
  endtask

  task automatic send_frame();
    for (int i = 0; i < swfe_pkg::FRAME_BYTES; i++)
      send_byte(frame_buf[i]);
  endtask

  // Random frame body; now and then the sync word is planted inside it,
  // where the core must not react to it.
  task automatic fill_random_frame();
    int unsigned at;
    for (int i = 0; i < swfe_pkg::FRAME_BYTES; i++)
      frame_buf[i] = rand_byte();
    if ($urandom_range(0, 9) == 0) begin
      at = $urandom_range(0, swfe_pkg::FRAME_BYTES - 4);
      for (int k = 0; k < 4; k++)
        frame_buf[at + k] = sync_setting[31 - 8 * k -: 8];
    end
  endtask

  // Stops the byte stream and waits until every predicted result has come
  // out, then gives the core the settle margin as well. The first edge lets the
  // scoreboard's count catch up with the last accepted byte.
  task automatic drain();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Programs the sync word. Only called while the core is idle.
  task automatic set_sync(input logic [31:0] word);
    sync_setting = word;
    settings_used++;
    sync_word_we    <= 1'b1;
    sync_word_wdata <= word;
    @(posedge clk);
    sync_word_we <= 1'b0;
  endtask

  // Result side: ready toggles with random gaps. Once enough frames have
  // gone through, it holds off for a long stretch while the byte stream
  // keeps running, so one result sits in the output register and the last
  // byte of the next frame stalls the input.
  initial begin : result_sink
    int unsigned run_len;
    int unsigned idle;
    angle_ch.ready = 1'b0;
    @(posedge clk);
    while (rst)
      @(posedge clk);
    forever begin
      if (!hold_done && frames_seen >= 8) begin
        hold_done = 1'b1;
        angle_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      angle_ch.ready <= 1'b1;
      run_len = $urandom_range(1, 12);
      repeat (run_len) @(posedge clk);
      idle = no_idle ? 0 : pick_gap();
      if (idle != 0) begin
        angle_ch.ready <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
  end

  // Watchdog: any byte or result beat restarts the count.
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (angle_ch.valid && angle_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned cut;
    int unsigned start;

    rst               = 1'b1;
    sync_word_we      = 1'b0;
    sync_word_wdata   = '0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    sync_setting      = swfe_pkg::SYNC_RESET;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, first under the reset sync word. Three leading sync
    // bytes that break off and then restart: the hunt must still lock on
    // the full word that follows.
    send_byte(sync_setting[31:24]);
    send_byte(sync_setting[23:16]);
    send_byte(sync_setting[15:8]);
    send_sync();

    // Frame with every angle byte at all ones and the rest at zero. The
    // sync word sits at its start and its first three bytes at its end;
    // neither may be seen inside the frame.
    for (int i = 0; i < swfe_pkg::FRAME_BYTES; i++)
      frame_buf[i] = (i >= swfe_pkg::YAW_FIRST
                      && i < swfe_pkg::YAW_FIRST + swfe_pkg::ANGLE_COUNT) ? 8'hff : 8'h00;
    for (int k = 0; k < 4; k++)
      frame_buf[k] = sync_setting[31 - 8 * k -: 8];
    for (int k = 0; k < 3; k++)
      frame_buf[swfe_pkg::FRAME_BYTES - 3 + k] = sync_setting[31 - 8 * k -: 8];
    send_frame();
    // This byte would complete the sync word only if the window had kept
    // shifting during the frame; it must not start one.
    send_byte(sync_setting[7:0]);

    // The sync word must arrive whole again; then a frame with all-zero
    // angle bytes and all-ones elsewhere.
    send_sync();
    for (int i = 0; i < swfe_pkg::FRAME_BYTES; i++)
      frame_buf[i] = (i >= swfe_pkg::YAW_FIRST
                      && i < swfe_pkg::YAW_FIRST + swfe_pkg::ANGLE_COUNT) ? 8'h00 : 8'hff;
    send_frame();
    drain();

    // A zero sync word: the window was cleared by the last frame, so a
    // single zero byte already matches after its shift.
    set_sync(32'h0000_0000);
    send_byte(8'h00);
    fill_random_frame();
    send_frame();
    drain();

    // The all-ones sync word.
    set_sync(32'hffff_ffff);
    send_sync();
    fill_random_frame();
    send_frame();
    drain();

    // Random phases, each under its own sync word. Most sequences are a
    // short noise lead-in, a sync word and a full frame; the rest are
    // broken sync words and plain noise. The second phase runs with no
    // gaps on either side.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          set_sync(swfe_pkg::SYNC_RESET);
        end
        2: begin
          set_sync(32'h0000_0000);
        end
        3: begin
          set_sync(32'hffff_ffff);
        end
        default: begin
          set_sync($urandom());
        end
      endcase
      no_idle = (phase == 1);
      start = sent_bytes;
      while (sent_bytes - start < PHASE_BYTES) begin
        pick = $urandom_range(0, 99);
        repeat ($urandom_range(0, 4)) send_byte(rand_byte());
        if (pick < 75) begin
          send_sync();
          fill_random_frame();
          send_frame();
        end else if (pick < 90) begin
          cut = $urandom_range(1, 3);
          for (int k = 0; k < cut; k++)
            send_byte(sync_setting[31 - 8 * k -: 8]);
          send_byte(rand_byte());
        end
      end
      drain();
    end
    no_idle = 1'b0;

    $display("Covered %0d byte beats and %0d frame results under %0d sync word settings.",
             bytes_seen, frames_seen, settings_used);
    $display("Result side held off once for %0d cycles while bytes kept coming.",
             HOLD_CYCLES);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
